/* sv/hbfr_pkg.sv */
package hbfr_pkg;

    localparam int HDR_BYTES = 4;
    localparam int HDR_IW    = $clog2(HDR_BYTES);
    localparam int LEN_W     = 6;
    localparam int ADDR_W    = 7;

    localparam logic [7:0] BYTE_ESC    = 8'hff;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] MAC_ACK     = 8'h01;
    localparam logic [7:0] MASTER_ADDR = 8'h08;
    localparam logic [7:0] MAC_TOP     = 8'h80;
    localparam logic [ADDR_W-1:0] ADDR_LOW  = 7'h08;
    localparam logic [ADDR_W-1:0] ADDR_NONE = 7'h00;
    localparam logic [ADDR_W-1:0] OWN_RESET = 7'd11;
    localparam int MIN_LONG = 6;

    typedef enum logic [2:0] {
        V_ACK      = 3'd0,
        V_RELEASE  = 3'd1,
        V_ASSIGN   = 3'd2,
        V_UNKNOWN  = 3'd3,
        V_SHORT    = 3'd4,
        V_WRONG    = 3'd5,
        V_BAD      = 3'd6,
        V_ACCEPTED = 3'd7
    } t_verdict;

    typedef enum logic [1:0] {
        L_RELEASED = 2'd0,
        L_ASSIGNED = 2'd1,
        L_WROTE    = 2'd2,
        L_READ     = 2'd3
    } t_link;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    // decoder event for the request in flight
    typedef struct packed {
        logic             echo;
        logic             eop;
        logic [7:0]       data;
        logic             single;
        logic             short_pkt;
        logic [LEN_W-1:0] length;
    } t_dec_evt;

    typedef struct packed {
        t_link             link;
        logic [ADDR_W-1:0] polled;
    } t_bus;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data;
        t_verdict          verdict;
        logic [LEN_W-1:0]  length;
        logic              seq_err;
        logic              poll;
        logic [ADDR_W-1:0] owner;
        t_link             state;
    } t_result;

endpackage

/* sv/hbfr_in_if.sv */
interface hbfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       abort_packet;

    modport source (output valid, output line_byte, output abort_packet, input ready);
    modport sink   (input valid, input line_byte, input abort_packet, output ready);
endinterface

/* sv/hbfr_out_if.sv */
interface hbfr_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] data_value;
    logic [2:0] verdict;
    logic [5:0] packet_length;
    logic       sequence_error;
    logic       poll_for_us;
    logic [6:0] bus_owner;
    logic [1:0] bus_state;

    modport source (output valid, output result_kind, output data_value, output verdict,
                    output packet_length, output sequence_error, output poll_for_us,
                    output bus_owner, output bus_state, input ready);
    modport sink   (input valid, input result_kind, input data_value, input verdict,
                    input packet_length, input sequence_error, input poll_for_us,
                    input bus_owner, input bus_state, output ready);
endinterface

/* sv/hbfr_cfg_if.sv */
interface hbfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] own_address;

    modport source (output valid, output own_address, input ready);
    modport sink   (input valid, input own_address, output ready);
endinterface

/* sv/heating_bus_frame_receiver.sv */
// Channel  | Dir | Payload                                            | Accept
// ---------+-----+----------------------------------------------------+-------------------
// i_in     | in  | line_byte, abort_packet                            | valid & ready
// o_out    | out | result_kind, data_value, verdict, packet_length,   | valid & ready
//          |     | sequence_error, poll_for_us, bus_owner, bus_state  |
// i_cfg    | in  | own_address                                        | valid & ready
//
// One line byte per cycle unless o_out stalls; a result appears in the cycle after its
// request is taken. Escape decode and the bus-ownership judge sit between the decoder
// state and the single output register; no other stage.
// i_in.ready drops only while the output register holds a result that o_out stalls.
// Synchronous active-low reset clears decoder, bus state, reply header; own_address gets 11.
module heating_bus_frame_receiver #(
    parameter int MAX_BYTES = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hbfr_in_if.sink    i_in,
    hbfr_out_if.source o_out,
    hbfr_cfg_if.sink   i_cfg
);

    logic                         accept;
    hbfr_pkg::t_dec_evt           evt;
    hbfr_pkg::t_hdr               hdr;
    hbfr_pkg::t_bus               r_bus, n_bus;
    hbfr_pkg::t_hdr               r_exp, n_exp;
    logic [hbfr_pkg::ADDR_W-1:0]  r_own;
    hbfr_pkg::t_verdict           verdict;
    logic                         seq_err;
    logic                         poll;
    logic                         r_out_valid;
    hbfr_pkg::t_result            r_res, n_res;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    hbfr_escape #(
        .MAX_BYTES (MAX_BYTES)
    ) u_escape (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.line_byte),
        .i_abort  (i_in.abort_packet),
        .o_evt    (evt),
        .o_hdr    (hdr)
    );

    hbfr_judge u_judge (
        .i_evt     (evt),
        .i_hdr     (hdr),
        .i_bus     (r_bus),
        .i_exp     (r_exp),
        .i_own     (r_own),
        .o_verdict (verdict),
        .o_seq_err (seq_err),
        .o_poll    (poll),
        .o_bus     (n_bus),
        .o_exp     (n_exp)
    );

    always_comb begin
        n_res = '0;
        if (evt.eop) begin
            n_res.kind    = 1'b1;
            n_res.verdict = verdict;
            n_res.length  = evt.length;
            n_res.seq_err = seq_err;
            n_res.poll    = poll;
            n_res.owner   = n_bus.polled;
            n_res.state   = n_bus.link;
        end else begin
            n_res.data    = evt.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus       <= '{link: hbfr_pkg::L_RELEASED, polled: hbfr_pkg::ADDR_NONE};
            r_exp       <= '0;
            r_own       <= hbfr_pkg::OWN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_own <= i_cfg.own_address;
            if (accept && evt.eop) begin
                r_bus <= n_bus;
                r_exp <= n_exp;
            end
            if (accept && (evt.echo || evt.eop)) r_out_valid <= 1'b1;
            else if (o_out.ready)                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (evt.echo || evt.eop)) r_res <= n_res;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_kind    = r_res.kind;
    assign o_out.data_value     = r_res.data;
    assign o_out.verdict        = r_res.verdict;
    assign o_out.packet_length  = r_res.length;
    assign o_out.sequence_error = r_res.seq_err;
    assign o_out.poll_for_us    = r_res.poll;
    assign o_out.bus_owner      = r_res.owner;
    assign o_out.bus_state      = r_res.state;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result stalled");

    a_poll_on_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.poll_for_us) |-> o_out.result_kind)
        else $error("poll_for_us on a data echo");

    a_release_clears_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind && o_out.verdict == hbfr_pkg::V_RELEASE)
        |-> (o_out.bus_owner == hbfr_pkg::ADDR_NONE && o_out.bus_state == hbfr_pkg::L_RELEASED))
        else $error("release verdict left bus owned");

    a_abort_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.abort_packet && !(o_out.valid && !o_out.ready)) |=> !o_out.valid)
        else $error("abort request produced a result");
`endif

endmodule

/* sv/hbfr_escape.sv */
module hbfr_escape #(
    parameter int MAX_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_abort,
    output hbfr_pkg::t_dec_evt o_evt,
    output hbfr_pkg::t_hdr     o_hdr
);

    localparam int CW = $clog2(MAX_BYTES + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FF_SEEN,
        PH_MARKED
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_count, n_count;
    hbfr_pkg::t_hdr  r_hdr;
    logic            take;
    logic            store;

    always_comb begin
        n_phase = r_phase;
        take    = 1'b0;
        o_evt   = '0;
        if (i_abort) begin
            n_phase = PH_IDLE;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_byte == hbfr_pkg::BYTE_ESC) n_phase = PH_FF_SEEN;
                    else take = 1'b1;
                end
                PH_FF_SEEN: begin
                    if (i_byte == hbfr_pkg::BYTE_ZERO) begin
                        n_phase = PH_MARKED;
                    end else begin
                        // doubled 0xff is a literal; any other follower is dropped
                        n_phase = PH_IDLE;
                        take    = (i_byte == hbfr_pkg::BYTE_ESC);
                    end
                end
                PH_MARKED: begin
                    n_phase = PH_IDLE;
                    if (i_byte == hbfr_pkg::BYTE_ZERO) o_evt.eop = 1'b1;
                    else take = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        store           = take && (r_count < CW'(MAX_BYTES));
        o_evt.echo      = store;
        o_evt.data      = i_byte;
        o_evt.single    = (r_count == CW'(1));
        o_evt.short_pkt = (r_count < CW'(hbfr_pkg::MIN_LONG));
        o_evt.length    = hbfr_pkg::LEN_W'(r_count);

        if (i_abort || o_evt.eop) n_count = '0;
        else if (store)           n_count = r_count + CW'(1);
        else                      n_count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && store && (r_count < CW'(hbfr_pkg::HDR_BYTES))) begin
            r_hdr[r_count[hbfr_pkg::HDR_IW-1:0]] <= i_byte;
        end
    end

    assign o_hdr = r_hdr;

endmodule

/* sv/hbfr_judge.sv */
module hbfr_judge (
    input  hbfr_pkg::t_dec_evt         i_evt,
    input  hbfr_pkg::t_hdr             i_hdr,
    input  hbfr_pkg::t_bus             i_bus,
    input  hbfr_pkg::t_hdr             i_exp,
    input  logic [hbfr_pkg::ADDR_W-1:0] i_own,
    output hbfr_pkg::t_verdict         o_verdict,
    output logic                       o_seq_err,
    output logic                       o_poll,
    output hbfr_pkg::t_bus             o_bus,
    output hbfr_pkg::t_hdr             o_exp
);

    logic [7:0]                  b0, b1;
    logic [hbfr_pkg::ADDR_W-1:0] dst;
    logic                        reply_ok;
    logic                        own_polled;

    always_comb begin
        b0         = i_hdr[0];
        b1         = i_hdr[1];
        dst        = b1[hbfr_pkg::ADDR_W-1:0];
        reply_ok   = (i_exp == i_hdr);
        own_polled = (i_bus.polled == i_own);

        o_verdict = hbfr_pkg::V_UNKNOWN;
        o_seq_err = 1'b0;
        o_poll    = 1'b0;
        o_bus     = i_bus;
        o_exp     = i_exp;

        if (i_evt.single) begin
            if (b0 == hbfr_pkg::MAC_ACK) begin
                o_verdict = hbfr_pkg::V_ACK;
                o_seq_err = (i_bus.link != hbfr_pkg::L_WROTE);
                if (own_polled) o_poll = 1'b1;
                else            o_bus.link = hbfr_pkg::L_ASSIGNED;
            end else if (b0 inside {[hbfr_pkg::MASTER_ADDR : hbfr_pkg::MAC_TOP - 8'd1]}) begin
                o_verdict    = hbfr_pkg::V_RELEASE;
                o_seq_err    = (i_bus.link != hbfr_pkg::L_ASSIGNED);
                o_bus.polled = hbfr_pkg::ADDR_NONE;
                o_bus.link   = hbfr_pkg::L_RELEASED;
            end else if (b0[7]) begin
                o_verdict    = hbfr_pkg::V_ASSIGN;
                o_seq_err    = (i_bus.link inside {hbfr_pkg::L_WROTE, hbfr_pkg::L_READ});
                o_bus.polled = b0[hbfr_pkg::ADDR_W-1:0];
                if (b0[hbfr_pkg::ADDR_W-1:0] == i_own) o_poll = 1'b1;
                else                                   o_bus.link = hbfr_pkg::L_ASSIGNED;
            end
        end else if (i_evt.short_pkt) begin
            o_verdict = hbfr_pkg::V_SHORT;
            if (i_bus.link inside {hbfr_pkg::L_WROTE, hbfr_pkg::L_READ}) begin
                o_bus.link = hbfr_pkg::L_ASSIGNED;
            end
        end else if (b0 == hbfr_pkg::MASTER_ADDR &&
                     (i_bus.link != hbfr_pkg::L_READ || !reply_ok)) begin
            // master frame that is not the awaited reply takes the bus back
            o_verdict  = hbfr_pkg::V_ACCEPTED;
            o_bus.link = hbfr_pkg::L_RELEASED;
        end else begin
            case (i_bus.link)
                hbfr_pkg::L_ASSIGNED: begin
                    if (b0 != {1'b0, i_bus.polled} && b0 != hbfr_pkg::MASTER_ADDR) begin
                        o_verdict = hbfr_pkg::V_WRONG;
                    end else if (b1[7]) begin
                        if (dst < hbfr_pkg::ADDR_LOW) begin
                            o_verdict = hbfr_pkg::V_BAD;
                        end else begin
                            // read request: remember the header the reply must carry
                            o_verdict  = hbfr_pkg::V_ACCEPTED;
                            o_exp[0]   = {1'b0, dst};
                            o_exp[1]   = b0;
                            o_exp[2]   = i_hdr[2];
                            o_exp[3]   = i_hdr[3];
                            o_bus.link = hbfr_pkg::L_READ;
                        end
                    end else begin
                        if (dst != hbfr_pkg::ADDR_NONE && dst < hbfr_pkg::ADDR_LOW) begin
                            o_verdict = hbfr_pkg::V_BAD;
                        end else begin
                            o_verdict = hbfr_pkg::V_ACCEPTED;
                            if (dst >= hbfr_pkg::ADDR_LOW) o_bus.link = hbfr_pkg::L_WROTE;
                        end
                    end
                end
                hbfr_pkg::L_READ: begin
                    o_bus.link = hbfr_pkg::L_ASSIGNED;
                    if (!reply_ok) begin
                        o_verdict = hbfr_pkg::V_BAD;
                    end else begin
                        o_verdict = hbfr_pkg::V_ACCEPTED;
                        o_poll    = own_polled;
                    end
                end
                hbfr_pkg::L_WROTE: o_verdict = hbfr_pkg::V_WRONG;
                default: begin
                    if (b0 != hbfr_pkg::MASTER_ADDR) o_verdict = hbfr_pkg::V_WRONG;
                    else                             o_verdict = hbfr_pkg::V_ACCEPTED;
                end
            endcase
        end
    end

endmodule
